/* sv/csq_pkg.sv */
`default_nettype none

package csq_pkg;

    localparam int LABEL_W        = 31;
    localparam int MAX_POINTS_DEF = 16;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_RD0,
        OP_A0,
        OP_SRCH_NEXT,
        OP_TRY_FWD,
        OP_TRY_REV,
        OP_WALK_START,
        OP_WALK_NEXT,
        OP_CLEAR
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   dir_rev;   // walk direction, taken with OP_WALK_START
        logic   res_load;  // load the output register
        logic   res_eq;    // equal flag for the loaded result
    } t_dp_cmd;

    typedef struct packed {
        logic fire;        // input beat taken this cycle
        logic pair_close;  // this beat completes the pair
        logic ovf;         // a list ran past the store
        logic len_ne;      // lengths differ
        logic n_zero;
        logic n_one;
        logic n_two;
        logic k_last;      // walk/search index at n-1
        logic b_hit;       // B read data equals A's first label
        logic pair_eq;     // A and B read data equal
        logic out_free;    // output register can take a result
    } t_dp_sts;

endpackage

`default_nettype wire

/* sv/csq_if.sv */
`default_nettype none

interface csq_in_if import csq_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [LABEL_W-1:0] point_label;
    logic               last_of_list;

    modport source (output valid, output req_type, output point_label,
                    output last_of_list, input ready);
    modport sink   (input valid, input req_type, input point_label,
                    input last_of_list, output ready);
endinterface

interface csq_out_if ();
    logic valid;
    logic ready;
    logic equal;
    logic overflow;

    modport source (output valid, output equal, output overflow, input ready);
    modport sink   (input valid, input equal, input overflow, output ready);
endinterface

`default_nettype wire

/* sv/cyclic_sequence_equality.sv */
// Loading: one label beat per cycle; ready is high whenever the block is loading.
// Compare: after the beat that closes the pair, the result is loaded into the output register
//   once that register is free: search walks B one entry a cycle through the store read
//   port, then the rest one pair a cycle.
// Each store has a single read port; no new labels are taken until the pair's result is loaded.
// Reset (i_rst_n low, synchronous): controller, counts, flags and output valid clear;
//   label stores keep their contents.
`default_nettype none

module cyclic_sequence_equality import csq_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    csq_in_if.sink    i_in,
    csq_out_if.source o_out
);

    // controller to datapath commands and back status
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // sequencer: load, length checks, search for A's first label in B,
    // direction probe (forward then reversed), wrap-around walk, result
    csq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // label stores, counts, index registers and the output register
    csq_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

/* sv/csq_dp.sv */
`default_nettype none

module csq_dp import csq_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    output t_dp_sts    o_sts,
    csq_in_if.sink     i_in,
    csq_out_if.source  o_out
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_POINTS);

    logic [LABEL_W-1:0] r_mem_a [MAX_POINTS];
    logic [LABEL_W-1:0] r_mem_b [MAX_POINTS];

    logic [CW-1:0]      r_cnt_a, r_cnt_b;
    logic               r_cpl_a, r_cpl_b, r_ovf;
    logic [LABEL_W-1:0] r_rd_a, r_rd_b, r_a0;
    logic [AW-1:0]      r_k, r_start, r_bp;
    logic               r_rev;
    logic               r_out_valid, r_out_eq, r_out_ovf;

    logic               w_fire, w_wr_a, w_wr_b, w_sel_cpl;
    logic [CW-1:0]      w_sel_cnt, w_nm1;
    logic [AW-1:0]      w_n_last, w_ra_a, w_ra_b;
    logic [AW-1:0]      w_k_inc, w_start_dec, w_bp_inc, w_bp_dec;

    assign i_in.ready = (i_cmd.op == OP_LOAD);
    assign w_fire     = i_in.valid && i_in.ready;

    assign w_sel_cpl = i_in.req_type ? r_cpl_b : r_cpl_a;
    assign w_sel_cnt = i_in.req_type ? r_cnt_b : r_cnt_a;
    assign w_wr_a    = w_fire && !i_in.req_type && !r_cpl_a && (r_cnt_a < MAX_CNT);
    assign w_wr_b    = w_fire &&  i_in.req_type && !r_cpl_b && (r_cnt_b < MAX_CNT);

    // circular index helpers over the list length n
    assign w_nm1       = r_cnt_a - CW'(1);
    assign w_n_last    = w_nm1[AW-1:0];
    assign w_k_inc     = (r_k == w_n_last) ? '0 : r_k + AW'(1);
    assign w_start_dec = (r_start == '0) ? w_n_last : r_start - AW'(1);
    assign w_bp_inc    = (r_bp == w_n_last) ? '0 : r_bp + AW'(1);
    assign w_bp_dec    = (r_bp == '0) ? w_n_last : r_bp - AW'(1);

    always_comb begin
        w_ra_a = '0;
        w_ra_b = '0;
        case (i_cmd.op)
            OP_SRCH_NEXT: begin
                w_ra_b = r_k + AW'(1);
            end
            OP_TRY_FWD: begin
                w_ra_a = AW'(1);
                w_ra_b = w_k_inc;
            end
            OP_TRY_REV: begin
                w_ra_a = AW'(1);
                w_ra_b = w_start_dec;
            end
            OP_WALK_START: begin
                w_ra_a = AW'(2);
                w_ra_b = i_cmd.dir_rev ? w_bp_dec : w_bp_inc;
            end
            OP_WALK_NEXT: begin
                w_ra_a = r_k + AW'(1);
                w_ra_b = r_rev ? w_bp_dec : w_bp_inc;
            end
            default: begin
                w_ra_a = '0;
                w_ra_b = '0;
            end
        endcase
    end

    // label stores
    always_ff @(posedge i_clk) begin
        if (w_wr_a) begin
            r_mem_a[r_cnt_a[AW-1:0]] <= i_in.point_label;
        end
        if (w_wr_b) begin
            r_mem_b[r_cnt_b[AW-1:0]] <= i_in.point_label;
        end
        r_rd_a <= r_mem_a[w_ra_a];
        r_rd_b <= r_mem_b[w_ra_b];
    end

    // list bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a <= '0;
            r_cnt_b <= '0;
            r_cpl_a <= 1'b0;
            r_cpl_b <= 1'b0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.op == OP_CLEAR) begin
            r_cnt_a <= '0;
            r_cnt_b <= '0;
            r_cpl_a <= 1'b0;
            r_cpl_b <= 1'b0;
            r_ovf   <= 1'b0;
        end else if (w_fire && !w_sel_cpl) begin
            if (w_wr_a) begin
                r_cnt_a <= r_cnt_a + CW'(1);
            end
            if (w_wr_b) begin
                r_cnt_b <= r_cnt_b + CW'(1);
            end
            if (w_sel_cnt >= MAX_CNT) begin
                r_ovf <= 1'b1;
            end
            if (i_in.last_of_list) begin
                if (i_in.req_type) begin
                    r_cpl_b <= 1'b1;
                end else begin
                    r_cpl_a <= 1'b1;
                end
            end
        end
    end

    // compare walk registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_A0: begin
                r_a0 <= r_rd_a;
                r_k  <= '0;
            end
            OP_SRCH_NEXT: begin
                r_k <= w_ra_b;
            end
            OP_TRY_FWD: begin
                r_start <= r_k;
                r_bp    <= w_ra_b;
            end
            OP_TRY_REV: begin
                r_bp <= w_ra_b;
            end
            OP_WALK_START: begin
                r_rev <= i_cmd.dir_rev;
                r_k   <= w_ra_a;
                r_bp  <= w_ra_b;
            end
            OP_WALK_NEXT: begin
                r_k  <= w_ra_a;
                r_bp <= w_ra_b;
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_out_eq  <= i_cmd.res_eq;
            r_out_ovf <= r_ovf;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.equal    = r_out_eq;
    assign o_out.overflow = r_out_ovf;

    always_comb begin
        o_sts.fire       = w_fire;
        o_sts.pair_close = w_fire && i_in.last_of_list &&
                           (i_in.req_type ? (!r_cpl_b && r_cpl_a) : (!r_cpl_a && r_cpl_b));
        o_sts.ovf        = r_ovf;
        o_sts.len_ne     = (r_cnt_a != r_cnt_b);
        o_sts.n_zero     = (r_cnt_a == CW'(0));
        o_sts.n_one      = (r_cnt_a == CW'(1));
        o_sts.n_two      = (r_cnt_a == CW'(2));
        o_sts.k_last     = (r_k == w_n_last);
        o_sts.b_hit      = (r_rd_b == r_a0);
        o_sts.pair_eq    = (r_rd_a == r_rd_b);
        o_sts.out_free   = !r_out_valid || o_out.ready;
    end

endmodule

`default_nettype wire

/* sv/csq_ctrl.sv */
`default_nettype none

module csq_ctrl import csq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [7:0] {
        S_LOAD  = 8'b0000_0001,
        S_START = 8'b0000_0010,
        S_A0    = 8'b0000_0100,
        S_SRCH  = 8'b0000_1000,
        S_FWD   = 8'b0001_0000,
        S_REV   = 8'b0010_0000,
        S_WALK  = 8'b0100_0000,
        S_RES   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_eq, n_eq;

    always_comb begin
        n_state        = r_state;
        n_eq           = r_eq;
        o_cmd.op       = OP_NONE;
        o_cmd.dir_rev  = 1'b0;
        o_cmd.res_load = 1'b0;
        o_cmd.res_eq   = r_eq;
        unique case (r_state)
            S_LOAD: begin
                o_cmd.op = OP_LOAD;
                if (i_sts.pair_close) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                if (i_sts.ovf || i_sts.len_ne) begin
                    n_eq    = 1'b0;
                    n_state = S_RES;
                end else if (i_sts.n_zero) begin
                    n_eq    = 1'b1;
                    n_state = S_RES;
                end else begin
                    o_cmd.op = OP_RD0;
                    n_state  = S_A0;
                end
            end
            S_A0: begin
                o_cmd.op = OP_A0;
                if (i_sts.n_one) begin
                    n_eq    = i_sts.pair_eq;
                    n_state = S_RES;
                end else begin
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                if (i_sts.b_hit) begin
                    o_cmd.op = OP_TRY_FWD;
                    n_state  = S_FWD;
                end else if (i_sts.k_last) begin
                    n_eq    = 1'b0;
                    n_state = S_RES;
                end else begin
                    o_cmd.op = OP_SRCH_NEXT;
                end
            end
            S_FWD: begin
                if (i_sts.pair_eq) begin
                    if (i_sts.n_two) begin
                        n_eq    = 1'b1;
                        n_state = S_RES;
                    end else begin
                        o_cmd.op = OP_WALK_START;
                        n_state  = S_WALK;
                    end
                end else begin
                    o_cmd.op = OP_TRY_REV;
                    n_state  = S_REV;
                end
            end
            S_REV: begin
                if (i_sts.pair_eq) begin
                    if (i_sts.n_two) begin
                        n_eq    = 1'b1;
                        n_state = S_RES;
                    end else begin
                        o_cmd.op      = OP_WALK_START;
                        o_cmd.dir_rev = 1'b1;
                        n_state       = S_WALK;
                    end
                end else begin
                    n_eq    = 1'b0;
                    n_state = S_RES;
                end
            end
            S_WALK: begin
                if (!i_sts.pair_eq) begin
                    n_eq    = 1'b0;
                    n_state = S_RES;
                end else if (i_sts.k_last) begin
                    n_eq    = 1'b1;
                    n_state = S_RES;
                end else begin
                    o_cmd.op = OP_WALK_NEXT;
                end
            end
            S_RES: begin
                if (i_sts.out_free) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.op       = OP_CLEAR;
                    n_state        = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_eq    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_eq    <= n_eq;
        end
    end

endmodule

`default_nettype wire

/* sv/csq_checker.sv */
`default_nettype none

module csq_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_equal,
    input logic i_out_overflow
);

    // a result beat holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_equal) && $stable(i_out_overflow))
        else $error("result payload changed while stalled");

    // an overflowed pair never reports a match
    a_ovf_ne: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_out_equal && i_out_overflow))
        else $error("equal set together with overflow");

    // a new result only comes out of the compare phase
    a_res_after_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared while loading");

    // loading stops only on a taken beat
    a_ready_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(i_in_ready) |-> $past(i_in_valid && i_in_ready))
        else $error("ready dropped without a taken beat");

endmodule

bind cyclic_sequence_equality csq_checker u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_equal    (o_out.equal),
    .i_out_overflow (o_out.overflow)
);

`default_nettype wire

/* sim/cyclic_sequence_equality_tb.sv */
`timescale 1ns / 1ps

module cyclic_sequence_equality_tb;
    import csq_pkg::*;

    localparam int STORE_DEPTH    = MAX_POINTS_DEF;
    localparam int RANDOM_LABELS  = 1850;   // list labels to queue, noise excluded
    localparam int WATCHDOG_LIMIT = 4000;   // quiet cycles before giving up
    localparam int DRAIN_CYCLES   = 64;     // wait after the last verdict for stray results

    // list selector carried in req_type
    typedef enum logic {
        LIST_A = 1'b0,
        LIST_B = 1'b1
    } t_list_sel;

    typedef logic [LABEL_W-1:0] t_label;

    typedef struct {
        t_list_sel sel;
        t_label    label;
        logic      last;
    } t_label_beat;

    typedef struct packed {
        logic equal;
        logic overflow;
    } t_verdict;

    logic i_clk;
    logic i_rst_n;

    csq_in_if  in_bus ();
    csq_out_if out_bus ();

    cyclic_sequence_equality #(
        .MAX_POINTS(STORE_DEPTH)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // 8 ns period
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Stimulus and scoreboard storage
    // ------------------------------------------------------------------
    t_label_beat pending_beats[$];      // beats still to be offered
    t_verdict    expected_verdicts[$];  // verdicts owed by the block
    int          total_beats;
    int          random_labels;
    int          fail_count;

    // ------------------------------------------------------------------
    // Shadow of the block: two label stores, counts, close flags
    // ------------------------------------------------------------------
    t_label shadow_a[STORE_DEPTH];
    t_label shadow_b[STORE_DEPTH];
    int     fill_a;
    int     fill_b;
    logic   closed_a;
    logic   closed_b;
    logic   ovf_pending;

    task automatic report_failure(string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        fail_count++;
    endtask

    // B equals A read circularly from the first hit of A[0] in B, direction
    // chosen by which neighbor of that hit holds A[1] (forward tried first)
    function automatic logic circular_match();
        int   n;
        int   start;
        int   ap;
        int   bp;
        int   dir;
        int   k;
        logic found;
        n     = fill_a;
        start = 0;
        dir   = 0;
        found = 1'b0;
        if (fill_a != fill_b) return 1'b0;
        if (n == 0) return 1'b1;
        if (n == 1) return shadow_a[0] == shadow_b[0];
        for (k = 0; k < n; k++) begin
            if (!found && shadow_b[k] == shadow_a[0]) begin
                start = k;
                found = 1'b1;
            end
        end
        if (!found) return 1'b0;
        bp = (start + 1 == n) ? 0 : start + 1;
        if (shadow_b[bp] == shadow_a[1]) begin
            dir = 1;
        end else begin
            bp = (start == 0) ? n - 1 : start - 1;
            if (shadow_b[bp] == shadow_a[1]) dir = -1;
        end
        if (dir == 0) return 1'b0;
        ap = 1;
        for (k = 2; k < n; k++) begin
            ap = (ap + 1 >= n) ? 0 : ap + 1;
            if (dir > 0) bp = (bp + 1 >= n) ? 0 : bp + 1;
            else         bp = (bp == 0) ? n - 1 : bp - 1;
            if (shadow_a[ap] != shadow_b[bp]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Apply one accepted beat to the shadow; queue a verdict when the pair closes
    task automatic absorb_label(t_label_beat beat);
        t_verdict v;
        if (beat.sel == LIST_B) begin
            if (closed_b) return;                 // list already closed: ignored
            if (fill_b < STORE_DEPTH) begin
                shadow_b[fill_b] = beat.label;
                fill_b++;
            end else begin
                ovf_pending = 1'b1;
            end
            if (beat.last) closed_b = 1'b1;
        end else begin
            if (closed_a) return;
            if (fill_a < STORE_DEPTH) begin
                shadow_a[fill_a] = beat.label;
                fill_a++;
            end else begin
                ovf_pending = 1'b1;
            end
            if (beat.last) closed_a = 1'b1;
        end
        if (!(closed_a && closed_b)) return;
        v.equal    = ovf_pending ? 1'b0 : circular_match();
        v.overflow = ovf_pending;
        expected_verdicts.push_back(v);
        fill_a      = 0;
        fill_b      = 0;
        closed_a    = 1'b0;
        closed_b    = 1'b0;
        ovf_pending = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic push_beat(t_list_sel sel, t_label label, logic last);
        t_label_beat b;
        b.sel   = sel;
        b.label = label;
        b.last  = last;
        pending_beats.push_back(b);
    endtask

    // alphabet: tiny (many repeats and hits), extremes, or the full 31 bits
    function automatic t_label pick_label(int mode);
        case (mode)
            0: pick_label = t_label'($urandom_range(3));
            1: pick_label = $urandom_range(1) ? '1 : '0;
            default: pick_label = t_label'($urandom());
        endcase
    endfunction

    function automatic int pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 8)       pick_length = $urandom_range(STORE_DEPTH + 4, STORE_DEPTH + 1);
        else if (r < 16) pick_length = STORE_DEPTH;
        else if (r < 30) pick_length = $urandom_range(2, 1);
        else             pick_length = $urandom_range(8, 3);
    endfunction

    // One pair: A random, B mostly a rotation or reflection of A, then the two lists
    // merged (interleaved, A first or B first), with stray beats aimed at an already closed list
    task automatic build_pair();
        t_label la[$];
        t_label lb[$];
        int     na;
        int     nb;
        int     mode;
        int     kind;
        int     rot;
        int     style;
        int     ia;
        int     ib;
        int     k;
        logic   take_a;
        na   = pick_length();
        mode = ($urandom_range(99) < 55) ? 0 : (($urandom_range(99) < 15) ? 1 : 2);
        for (k = 0; k < na; k++) la.push_back(pick_label(mode));
        kind = $urandom_range(99);
        rot  = $urandom_range(na - 1);
        if (kind < 45) begin                       // forward rotation
            for (k = 0; k < na; k++) lb.push_back(la[(k + rot) % na]);
        end else if (kind < 70) begin              // reversed rotation
            for (k = 0; k < na; k++) lb.push_back(la[(rot - k + na) % na]);
        end else if (kind < 80) begin              // rotation with one label changed
            for (k = 0; k < na; k++) lb.push_back(la[(k + rot) % na]);
            lb[$urandom_range(na - 1)] = pick_label(mode);
        end else if (kind < 88) begin              // length off by a few
            nb = na + ($urandom_range(1) ? $urandom_range(3, 1) : -$urandom_range(3, 1));
            if (nb < 1) nb = na + 1;
            for (k = 0; k < nb; k++) lb.push_back(la[(k + rot) % na]);
        end else if (kind < 93) begin              // B runs past the store
            nb = $urandom_range(STORE_DEPTH + 4, STORE_DEPTH + 1);
            for (k = 0; k < nb; k++) lb.push_back(pick_label(mode));
        end else begin                             // unrelated content, same length
            for (k = 0; k < na; k++) lb.push_back(pick_label(mode));
        end
        nb    = lb.size();
        style = $urandom_range(2);                 // 0 interleave, 1 A first, 2 B first
        ia    = 0;
        ib    = 0;
        while (ia < na || ib < nb) begin
            if (((ia == na) != (ib == nb)) && $urandom_range(9) == 0)
                push_beat((ia == na) ? LIST_A : LIST_B, pick_label(2), 1'($urandom_range(1)));
            take_a = (ia < na) && (ib >= nb || style == 1 ||
                                   (style == 0 && $urandom_range(1) == 1));
            if (take_a) begin
                push_beat(LIST_A, la[ia], ia == na - 1);
                ia++;
            end else begin
                push_beat(LIST_B, lb[ib], ib == nb - 1);
                ib++;
            end
            random_labels++;
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: offers pending beats and drives the result ready.
    // Idle mix follows beats taken: sender 19% / receiver 69%, then swapped,
    // then neither side idles.
    // ------------------------------------------------------------------
    int          beats_taken;
    int          send_idle;
    int          recv_idle;
    t_label_beat next_beat;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid  <= 1'b0;
            out_bus.ready <= 1'b0;
        end else begin
            if (in_bus.valid && in_bus.ready) beats_taken++;
            if (beats_taken < total_beats / 3) begin
                send_idle = 19;
                recv_idle = 69;
            end else if (beats_taken < (2 * total_beats) / 3) begin
                send_idle = 69;
                recv_idle = 19;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            out_bus.ready <= ($urandom_range(99) >= recv_idle);
            // only move on once the current beat is gone
            if (!in_bus.valid || in_bus.ready) begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle) begin
                    next_beat           = pending_beats.pop_front();
                    in_bus.valid        <= 1'b1;
                    in_bus.req_type     <= next_beat.sel;
                    in_bus.point_label  <= next_beat.label;
                    in_bus.last_of_list <= next_beat.last;
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks results against the oldest verdict, feeds accepted
    // labels to the shadow, and runs the watchdog.
    // ------------------------------------------------------------------
    int          quiet_cycles;
    t_verdict    want;
    t_label_beat seen_beat;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_bus.valid && out_bus.ready) begin
                if (expected_verdicts.size() == 0) begin
                    report_failure($sformatf("result with nothing pending (equal=%0b overflow=%0b)",
                                             out_bus.equal, out_bus.overflow));
                end else begin
                    want = expected_verdicts.pop_front();
                    if (out_bus.equal !== want.equal)
                        report_failure($sformatf("equal got %0b want %0b",
                                                 out_bus.equal, want.equal));
                    if (out_bus.overflow !== want.overflow)
                        report_failure($sformatf("overflow got %0b want %0b",
                                                 out_bus.overflow, want.overflow));
                end
            end
            if (in_bus.valid && in_bus.ready) begin
                seen_beat.sel   = t_list_sel'(in_bus.req_type);
                seen_beat.label = in_bus.point_label;
                seen_beat.last  = in_bus.last_of_list;
                absorb_label(seen_beat);
            end
            if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: known inputs, stimulus, reset, drain, verdict
    // ------------------------------------------------------------------
    initial begin
        i_rst_n             = 1'b0;
        in_bus.valid        = 1'b0;
        in_bus.req_type     = 1'b0;
        in_bus.point_label  = '0;
        in_bus.last_of_list = 1'b0;
        out_bus.ready       = 1'b0;
        fill_a              = 0;
        fill_b              = 0;
        closed_a            = 1'b0;
        closed_b            = 1'b0;
        ovf_pending         = 1'b0;
        fail_count          = 0;
        beats_taken         = 0;
        quiet_cycles        = 0;
        random_labels       = 0;

        // single labels, top of range, equal
        push_beat(LIST_A, '1, 1'b1);
        push_beat(LIST_B, '1, 1'b1);
        // single labels, zero vs one
        push_beat(LIST_B, 31'd1, 1'b1);
        push_beat(LIST_A, 31'd0, 1'b1);
        // two labels swapped
        push_beat(LIST_A, 31'd5, 1'b0);
        push_beat(LIST_B, 31'd9, 1'b0);
        push_beat(LIST_A, 31'd9, 1'b1);
        push_beat(LIST_B, 31'd5, 1'b1);
        // lengths differ
        push_beat(LIST_A, 31'd1, 1'b0);
        push_beat(LIST_A, 31'd2, 1'b1);
        push_beat(LIST_B, 31'd1, 1'b1);
        // repeated first label: only the first hit in B is the start point
        push_beat(LIST_A, 31'd1, 1'b0);
        push_beat(LIST_A, 31'd2, 1'b0);
        push_beat(LIST_A, 31'd1, 1'b0);
        push_beat(LIST_A, 31'd3, 1'b1);
        push_beat(LIST_B, 31'd1, 1'b0);
        push_beat(LIST_B, 31'd1, 1'b0);
        push_beat(LIST_B, 31'd3, 1'b0);
        push_beat(LIST_B, 31'd2, 1'b1);
        // stray label for a closed list while the other still loads
        push_beat(LIST_A, 31'd6, 1'b1);
        push_beat(LIST_A, 31'h2AAA_AAAA, 1'b1);
        push_beat(LIST_B, 31'd6, 1'b1);

        while (random_labels < RANDOM_LABELS) build_pair();
        total_beats = pending_beats.size();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // everything offered and taken, then every verdict back
        while (pending_beats.size() != 0 || in_bus.valid) @(posedge i_clk);
        while (expected_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_verdicts.size() != 0)
            report_failure($sformatf("%0d verdicts never arrived", expected_verdicts.size()));

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/csq_pkg.sv
sv/csq_if.sv
sv/csq_dp.sv
sv/csq_ctrl.sv
sv/cyclic_sequence_equality.sv
sv/csq_checker.sv
sim/cyclic_sequence_equality_tb.sv
